// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the lidar frame parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== rtl/core/lfp_pkg.sv =====
// Types and constants of the lidar frame parser.
`timescale 1ns / 1ps
`default_nettype none

package lfp_pkg;

    localparam logic [7:0] MAX_MEASURES = 8'd64;
    localparam logic [7:0] BOUND_BYTE   = 8'hFF;
    localparam logic [7:0] ACT_MAX      = 8'd16;
    localparam logic [7:0] ROI_BYTE_MAX = 8'd14;
    localparam logic [3:0] ROI_RESET    = 4'd4;
    localparam logic [1:0] RUN_LAST     = 2'd2;
    localparam logic [2:0] DIV_LAST     = 3'd7;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_MEAS   = 2'd1,
        KIND_END    = 2'd2,
        KIND_BAD    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_HDR1 = 3'd1,
        PH_HDR2 = 3'd2,
        PH_REC0 = 3'd3,
        PH_REC1 = 3'd4,
        PH_REC2 = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        JOB_EMPTY = 2'd0,
        JOB_DIV   = 2'd1,
        JOB_READY = 2'd2
    } job_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  active_sensors;
        logic        header_valid;
        logic [7:0]  measures_announced;
        logic [15:0] distance;
        logic [7:0]  measure_count;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/lidar_frame_parser_top.sv =====
// Lidar frame parser top level: byte-level frame decoding with a bit-serial divider.
// Header, frame end and bad-record results go from the byte that causes them through the job
//   slot and the output register to m_valid; measurements first take the 8-step divider.
// A byte that causes no result leaves s_ready high; one that causes a result holds s_ready low
//   until the result moves to the output register; the divider makes one quotient bit a cycle.
// Reset: synchronous, active low; clears parser state, job slot, output valid, roi_count to 4.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lidar_frame_parser_top
    import lfp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_wdata,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [7:0]       m_active_sensors,
    output logic             m_header_valid,
    output logic [7:0]       m_measures_announced,
    output logic [7:0]       m_sensor_number,
    output logic [3:0]       m_roi_index,
    output logic [15:0]      m_distance,
    output logic [7:0]       m_measure_count
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [3:0] roi_reg;

    // Always take a configuration transfer; writes must arrive only while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roi_reg <= ROI_RESET;
        end else if (cfg_valid && cfg_ready) begin
            roi_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    logic        in_frame_reg,  in_frame_next;
    logic [1:0]  run_reg,       run_next;
    phase_t      phase_reg,     phase_next;
    logic [15:0] held_reg,      held_next;    // partial header or record, newest byte low
    logic        pend_vld_reg,  pend_vld_next;
    logic [23:0] pend_rec_reg,  pend_rec_next;
    logic [7:0]  stored_reg,    stored_next;

    // Result produced by the byte on s_rx_byte, used only on a transfer.
    res_t        res;
    logic        res_valid;
    logic        res_div;
    logic [7:0]  res_dividend;

    logic        s_xfer;
    logic        is_ff;
    logic [23:0] emit_rec;
    logic        emit;
    logic [23:0] rec_full;

    assign s_xfer   = s_valid && s_ready;
    assign is_ff    = (s_rx_byte == BOUND_BYTE);
    assign rec_full = {held_reg, s_rx_byte};

    always_comb begin
        in_frame_next = in_frame_reg;
        run_next      = run_reg;
        phase_next    = phase_reg;
        held_next     = held_reg;
        pend_vld_next = pend_vld_reg;
        pend_rec_next = pend_rec_reg;
        stored_next   = stored_reg;
        res           = '0;
        res_valid     = 1'b0;
        res_div       = 1'b0;
        res_dividend  = 8'd0;
        emit          = 1'b0;
        emit_rec      = 24'd0;

        if (!in_frame_reg) begin
            // Hunt for the opening run of three bound bytes.
            if (is_ff) begin
                if (run_reg >= RUN_LAST) begin
                    in_frame_next = 1'b1;
                    run_next      = 2'd0;
                    phase_next    = PH_WAIT;
                    held_next     = 16'd0;
                    pend_vld_next = 1'b0;
                    pend_rec_next = 24'd0;
                    stored_next   = 8'd0;
                end else begin
                    run_next = run_reg + 2'd1;
                end
            end else begin
                run_next = 2'd0;
            end
        end else if (phase_reg == PH_WAIT) begin
            // Skip extra bound bytes, then take the first header byte.
            if (!is_ff) begin
                held_next  = {8'd0, s_rx_byte};
                phase_next = PH_HDR1;
                run_next   = 2'd0;
            end
        end else if (is_ff && (run_reg >= RUN_LAST)) begin
            // Closing run complete: report frame end, drop any pending record.
            res.kind       = KIND_END;
            res.measure_count = stored_reg;
            res_valid      = 1'b1;
            in_frame_next  = 1'b0;
            run_next       = 2'd0;
            phase_next     = PH_WAIT;
            held_next      = 16'd0;
            pend_vld_next  = 1'b0;
            pend_rec_next  = 24'd0;
        end else begin
            if (is_ff) begin
                run_next = run_reg + 2'd1;
            end else begin
                run_next = 2'd0;
                // A non-bound byte proves the held-back record was data.
                if (pend_vld_reg) begin
                    emit          = 1'b1;
                    emit_rec      = pend_rec_reg;
                    pend_vld_next = 1'b0;
                    pend_rec_next = 24'd0;
                end
            end

            unique case (phase_reg)
                PH_HDR1: begin
                    held_next  = {held_reg[7:0], s_rx_byte};
                    phase_next = PH_HDR2;
                end
                PH_HDR2: begin
                    res.kind               = KIND_HEADER;
                    res.active_sensors     = held_reg[15:8];
                    res.header_valid       = (held_reg[15:8] != 8'd0) &&
                                             (held_reg[15:8] <= ACT_MAX) &&
                                             (held_reg[7:0] <= ROI_BYTE_MAX);
                    res.measures_announced = s_rx_byte;
                    res_valid              = 1'b1;
                    held_next              = 16'd0;
                    phase_next             = PH_REC0;
                end
                PH_REC0: begin
                    held_next  = {8'd0, s_rx_byte};
                    phase_next = PH_REC1;
                end
                PH_REC1: begin
                    held_next  = {held_reg[7:0], s_rx_byte};
                    phase_next = PH_REC2;
                end
                PH_REC2: begin
                    held_next  = 16'd0;
                    phase_next = PH_REC0;
                    if (stored_reg < MAX_MEASURES) begin
                        if (!is_ff) begin
                            emit     = 1'b1;
                            emit_rec = rec_full;
                        end else begin
                            // Hold it back: this byte may open the closing run.
                            pend_vld_next = 1'b1;
                            pend_rec_next = rec_full;
                        end
                    end
                end
                default: begin
                    phase_next = PH_WAIT;
                end
            endcase

            if (emit) begin
                stored_next       = stored_reg + 8'd1;
                res.distance      = emit_rec[15:0];
                res.measure_count = stored_reg + 8'd1;
                res_valid         = 1'b1;
                if (emit_rec[23:16] == 8'd0) begin
                    res.kind = KIND_BAD;
                end else begin
                    res.kind     = KIND_MEAS;
                    res_div      = 1'b1;
                    res_dividend = emit_rec[23:16] - 8'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            run_reg      <= 2'd0;
            phase_reg    <= PH_WAIT;
            held_reg     <= 16'd0;
            pend_vld_reg <= 1'b0;
            pend_rec_reg <= 24'd0;
            stored_reg   <= 8'd0;
        end else if (s_xfer) begin
            in_frame_reg <= in_frame_next;
            run_reg      <= run_next;
            phase_reg    <= phase_next;
            held_reg     <= held_next;
            pend_vld_reg <= pend_vld_next;
            pend_rec_reg <= pend_rec_next;
            stored_reg   <= stored_next;
        end
    end

    // ------------------------------------------------------------------
    // Job slot with bit-serial restoring divider
    // ------------------------------------------------------------------
    job_t        job_reg, job_next;
    res_t        job_res_reg;
    logic [3:0]  div_reg;      // divisor, zero roi_count acts as one
    logic [7:0]  qd_reg;       // dividend shifts out the top, quotient shifts in the bottom
    logic [3:0]  rem_reg;
    logic [2:0]  cnt_reg;

    logic        out_vld_reg;
    logic        out_free;
    logic        job_load;
    logic        job_move;
    logic [4:0]  trial;
    logic        trial_ge;
    logic [4:0]  trial_diff;

    assign s_ready  = (job_reg == JOB_EMPTY);
    assign out_free = !out_vld_reg || m_ready;

    assign trial      = {rem_reg, qd_reg[7]};
    assign trial_ge   = (trial >= {1'b0, div_reg});
    assign trial_diff = trial - {1'b0, div_reg};

    always_comb begin
        job_next = job_reg;
        job_load = 1'b0;
        job_move = 1'b0;
        unique case (job_reg)
            JOB_EMPTY: begin
                if (s_xfer && res_valid) begin
                    job_load = 1'b1;
                    job_next = res_div ? JOB_DIV : JOB_READY;
                end
            end
            JOB_DIV: begin
                if (cnt_reg == DIV_LAST) begin
                    job_next = JOB_READY;
                end
            end
            JOB_READY: begin
                if (out_free) begin
                    job_move = 1'b1;
                    job_next = JOB_EMPTY;
                end
            end
            default: begin
                job_next = JOB_EMPTY;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_reg <= JOB_EMPTY;
            cnt_reg <= 3'd0;
        end else begin
            job_reg <= job_next;
            if (job_load) begin
                cnt_reg <= 3'd0;
            end else if (job_reg == JOB_DIV) begin
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    // Payload of the job slot and divider datapath.
    always_ff @(posedge aclk) begin
        if (job_load) begin
            job_res_reg <= res;
            div_reg     <= (roi_reg == 4'd0) ? 4'd1 : roi_reg;
            qd_reg      <= res_dividend;
            rem_reg     <= 4'd0;
        end else if (job_reg == JOB_DIV) begin
            // Advance one quotient bit: subtract where the trial remainder allows.
            qd_reg  <= {qd_reg[6:0], trial_ge};
            rem_reg <= trial_ge ? trial_diff[3:0] : trial[3:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    res_t       out_res_reg;
    logic [7:0] out_sensor_reg;
    logic [3:0] out_roi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (job_move) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    // Non-measurement jobs load zero dividend, so quotient and remainder read zero.
    always_ff @(posedge aclk) begin
        if (job_move) begin
            out_res_reg    <= job_res_reg;
            out_sensor_reg <= qd_reg;
            out_roi_reg    <= rem_reg;
        end
    end

    assign m_valid              = out_vld_reg;
    assign m_kind               = out_res_reg.kind;
    assign m_active_sensors     = out_res_reg.active_sensors;
    assign m_header_valid       = out_res_reg.header_valid;
    assign m_measures_announced = out_res_reg.measures_announced;
    assign m_sensor_number      = out_sensor_reg;
    assign m_roi_index          = out_roi_reg;
    assign m_distance           = out_res_reg.distance;
    assign m_measure_count      = out_res_reg.measure_count;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_stored_capped, aclk, aresetn, 1'b1, stored_reg <= MAX_MEASURES)
    `ASSERT_IMPL(a_pend_phase, aclk, aresetn, pend_vld_reg,
        in_frame_reg && (phase_reg == PH_REC0 || phase_reg == PH_REC1))
    `ASSERT_NEXT(a_div_done, aclk, aresetn, job_reg == JOB_DIV && cnt_reg == DIV_LAST,
        job_reg == JOB_READY)
    `ASSERT_IMPL(a_zero_decode, aclk, aresetn, out_vld_reg && out_res_reg.kind != KIND_MEAS,
        out_sensor_reg == 8'd0 && out_roi_reg == 4'd0)

endmodule

`default_nettype wire
